[design/lfu_pkg.sv]
// Shared types and constants for the least-frequently-used cache store.
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int USES_W = 16;
  localparam int TOUCH_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [USES_W-1:0] USES_MAX   = 16'hFFFF;
  localparam logic [USES_W-1:0] USES_FIRST = 16'd1;

  // Operation codes carried on the input tuser
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DECIDE
  } lfu_state_t;

  // One stored slot, as kept in the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [USES_W-1:0]  uses;
    logic [TOUCH_W-1:0] touch;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Summary gathered by the scan unit over one pass
  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  hit_data;
    logic [USES_W-1:0]  hit_uses;
    logic [KEY_W-1:0]   victim_key;
  } scan_res_t;

endpackage

[design/lfu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/lfu_scan.sv]
// Shared compare unit: key match, victim choice and free slot search, one entry a cycle.
`timescale 1ns / 1ps

module lfu_scan
  import lfu_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             sample,
  input  logic [IDX_W-1:0] sample_idx,
  input  logic             sample_valid,
  input  entry_t           sample_entry,
  input  logic [KEY_W-1:0] key,
  output scan_res_t        res,
  output logic [IDX_W-1:0] hit_idx,
  output logic [IDX_W-1:0] victim_idx,
  output logic [IDX_W-1:0] free_idx
);

  logic               hit_r, hit_nxt;
  logic [DATA_W-1:0]  hit_data_r, hit_data_nxt;
  logic [USES_W-1:0]  hit_uses_r, hit_uses_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               best_vld_r, best_vld_nxt;
  logic [USES_W-1:0]  best_uses_r, best_uses_nxt;
  logic [TOUCH_W-1:0] best_touch_r, best_touch_nxt;
  logic [KEY_W-1:0]   best_key_r, best_key_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic               free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic               match;
  logic               better;

  // Compare the arriving entry against the key and the running best
  always_comb begin
    match  = sample_valid && (sample_entry.key == key);
    better = sample_valid &&
             (!best_vld_r || (sample_entry.uses < best_uses_r) ||
              ((sample_entry.uses == best_uses_r) && (sample_entry.touch < best_touch_r)));

    hit_nxt        = hit_r;
    hit_data_nxt   = hit_data_r;
    hit_uses_nxt   = hit_uses_r;
    hit_idx_nxt    = hit_idx_r;
    best_vld_nxt   = best_vld_r;
    best_uses_nxt  = best_uses_r;
    best_touch_nxt = best_touch_r;
    best_key_nxt   = best_key_r;
    best_idx_nxt   = best_idx_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;

    if (start) begin
      hit_nxt      = 1'b0;
      best_vld_nxt = 1'b0;
      free_vld_nxt = 1'b0;
    end else if (sample) begin
      // keep the first match
      if (match && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_data_nxt = sample_entry.data;
        hit_uses_nxt = sample_entry.uses;
        hit_idx_nxt  = sample_idx;
      end
      // lower uses wins, then older touch; strict compare keeps the lowest slot on full ties
      if (better) begin
        best_vld_nxt   = 1'b1;
        best_uses_nxt  = sample_entry.uses;
        best_touch_nxt = sample_entry.touch;
        best_key_nxt   = sample_entry.key;
        best_idx_nxt   = sample_idx;
      end
      // first empty slot
      if (!sample_valid && !free_vld_r) begin
        free_vld_nxt = 1'b1;
        free_idx_nxt = sample_idx;
      end
    end
  end

  // Flags need reset; the captured payload does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
    end else begin
      hit_r      <= hit_nxt;
      best_vld_r <= best_vld_nxt;
      free_vld_r <= free_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_data_r   <= hit_data_nxt;
    hit_uses_r   <= hit_uses_nxt;
    hit_idx_r    <= hit_idx_nxt;
    best_uses_r  <= best_uses_nxt;
    best_touch_r <= best_touch_nxt;
    best_key_r   <= best_key_nxt;
    best_idx_r   <= best_idx_nxt;
    free_idx_r   <= free_idx_nxt;
  end

  assign res.hit        = hit_r;
  assign res.hit_data   = hit_data_r;
  assign res.hit_uses   = hit_uses_r;
  assign res.victim_key = best_key_r;
  assign hit_idx        = hit_idx_r;
  assign victim_idx     = best_idx_r;
  assign free_idx       = free_idx_r;

endmodule

[design/lfu_cache_store.sv]
// Least-frequently-used key/value cache store, top level.
//
// Channels: in_* carries one request per transfer (tuser = op, 0 get, 1 put;
// tdata = key then put_value). out_* returns exactly one result per request
// (tdata = found, read_value, evicted, evicted_key from bit 0 up). cfg_*
// writes the capacity register; write it only while no request is in flight.
//
// Sequencing: a request goes from ST_IDLE through ST_SCAN and ST_WAIT to ST_DECIDE.
// The entry memory has one read port and every request reads each slot once
// through the shared compare unit, then ST_DECIDE decides and writes back. A
// new request is taken in the cycle after the result is registered; no new
// request is taken while one is being scanned or decided.
//
// Reset: all slots empty, touch counter and occupancy zero, capacity 16. No
// clearing pass is needed; slot valid bits live in flip-flops.
//
// Stall: the result waits in the output register while out_tready is low; the
// next request may be taken and scanned, and its write-back is held until the
// output register is free.
`timescale 1ns / 1ps

module lfu_cache_store
  import lfu_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // request stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // [31:0] key, [63:32] put_value
  input  logic             in_tuser,   // [0] op
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,  // [0] found, [32:1] read_value, [33] evicted,
                                       // [65:34] evicted_key, [71:66] zero
  // capacity register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  lfu_state_t              state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    pend_vld_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic                    op_r;
  logic [KEY_W-1:0]        key_r;
  logic [DATA_W-1:0]       val_r;
  logic [CAP_W-1:0]        capacity_r;
  logic [MAX_ENTRIES-1:0]  valid_r;
  logic [OCC_W-1:0]        occ_r;
  logic [TOUCH_W-1:0]      touch_r;
  logic                    out_valid_r;
  logic [71:0]             out_data_r;

  logic                    accept;
  logic                    scan_start;
  logic                    rd_en;
  entry_t                  rd_entry;
  logic [ENTRY_W-1:0]      rd_word;
  scan_res_t               res;
  logic [IDX_W-1:0]        hit_idx, victim_idx, free_idx;

  logic                    can_load, commit;
  logic                    full, cap_zero;
  logic [USES_W-1:0]       uses_inc;
  logic [DATA_W-1:0]       rd_val;
  logic                    ev;
  logic [KEY_W-1:0]        ev_key;
  logic                    wr_req;
  logic [IDX_W-1:0]        wr_idx;
  entry_t                  wr_entry;
  logic                    occ_inc;

  // Entry memory: one read per scan cycle, one write at decide
  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (commit && wr_req),
    .wr_addr (wr_idx),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  // Shared compare unit walks the slots as their data arrives
  lfu_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (scan_start),
    .sample       (pend_vld_r),
    .sample_idx   (pend_idx_r),
    .sample_valid (valid_r[pend_idx_r]),
    .sample_entry (rd_entry),
    .key          (key_r),
    .res          (res),
    .hit_idx      (hit_idx),
    .victim_idx   (victim_idx),
    .free_idx     (free_idx)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    in_tready  = 1'b0;
    rd_en      = 1'b0;
    scan_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          scan_start = 1'b1;
          idx_nxt    = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign accept    = in_tvalid && in_tready;
  assign can_load  = !out_valid_r || out_tready;
  assign commit    = (state_r == ST_DECIDE) && can_load;
  assign cap_zero  = (capacity_r == '0);
  assign full      = (CMP_W'(occ_r) >= CMP_W'(capacity_r)) ||
                     (occ_r >= OCC_W'(MAX_ENTRIES));
  assign uses_inc  = (res.hit_uses == USES_MAX) ? res.hit_uses : res.hit_uses + 1'b1;

  // Decide the result and the write-back from the scan summary
  always_comb begin
    rd_val         = '0;
    ev             = 1'b0;
    ev_key         = '0;
    wr_req         = 1'b0;
    wr_idx         = hit_idx;
    occ_inc        = 1'b0;
    wr_entry.key   = key_r;
    wr_entry.data  = val_r;
    wr_entry.uses  = uses_inc;
    wr_entry.touch = touch_r;
    if (op_r == OP_GET) begin
      if (res.hit) begin
        rd_val        = res.hit_data;
        wr_req        = 1'b1;
        wr_entry.data = res.hit_data;
      end else begin
        rd_val = MISS_VALUE;
      end
    end else if (!cap_zero) begin
      wr_req = 1'b1;
      if (!res.hit) begin
        wr_entry.uses = USES_FIRST;
        if (full) begin
          ev     = 1'b1;
          ev_key = res.victim_key;
          wr_idx = victim_idx;
        end else begin
          wr_idx  = free_idx;
          occ_inc = 1'b1;
        end
      end
    end
  end

  assign cfg_ready = 1'b1;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_vld_r  <= 1'b0;
      capacity_r  <= CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      touch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= rd_en;
      if (cfg_valid) begin
        capacity_r <= cfg_data;
      end
      if (commit && wr_req) begin
        valid_r[wr_idx] <= 1'b1;
        touch_r         <= touch_r + 1'b1;
      end
      if (commit && occ_inc) begin
        occ_r <= occ_r + 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pend_idx_r <= idx_r;
    if (accept) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[31:0];
      val_r <= in_tdata[63:32];
    end
    if (commit) begin
      out_data_r <= {6'b0, ev_key, ev, rd_val, res.hit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Occupancy tracks the valid bits exactly
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy differs from valid bit count");

  // An eviction is only reported for a key that was not present
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && ev) |-> !res.hit)
    else $error("eviction on a hit");

  // A committed item frees the sequencer for the next request
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("commit did not return to idle with a result");

  // A stalled result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("pending result changed under stall");

  // The scan ends at the last slot and never reads past it
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && idx_r == LAST_IDX) |=> (state_r == ST_WAIT))
    else $error("scan overran the last slot");

endmodule
